// ===== rtl/gmw_pkg.sv =====
// Shared types and constants for the grid maze walker.
package gmw_pkg;

   localparam int GRID_SIDE = 16;
   localparam int COORD_W   = 4;
   localparam int SPAN      = (GRID_SIDE < 16) ? GRID_SIDE : 16;
   localparam int DEPTH     = SPAN * SPAN;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] KIND_OPEN    = 2'd0;
   localparam logic [1:0] KIND_WALL    = 2'd1;
   localparam logic [1:0] KIND_EXIT    = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   typedef enum logic [2:0] {
      CELL_OPEN  = 3'd0,
      CELL_WALL  = 3'd1,
      CELL_EXIT  = 3'd2,
      CELL_ONCE  = 3'd3,
      CELL_TWICE = 3'd4,
      CELL_HERE  = 3'd5
   } cell_type;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_STEP  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_LOADED  = 3'd0,
      ST_STARTED = 3'd1,
      ST_REJECT  = 3'd2,
      ST_MOVED   = 3'd3,
      ST_ESCAPED = 3'd4,
      ST_TRAPPED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WALK = 2'd1,
      PH_ESC  = 2'd2,
      PH_TRAP = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      GMW_IDLE,
      GMW_READ,
      GMW_LAST,
      GMW_DECIDE,
      GMW_MOVE,
      GMW_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [1:0]         cell_kind;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pos_row;
      logic [COORD_W-1:0] pos_col;
      logic [2:0]         status;
   } rsp_type;

endpackage

// ===== rtl/grid_maze_walker.sv =====
// Grid maze walker: one grid memory, read-modify-write sequencer.
// Takes one request at a time; a step that moves the walker does four neighbour reads and
// two cell writes through the grid memory's one read port and one write port.
// Reset (synchronous, active high) clears the walker, its phase and all cell valid
// bits; a cell never written since reset reads as a wall.
module grid_maze_walker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gmw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gmw_pkg::rsp_type rsp_data
);
   import gmw_pkg::*;

   logic [2:0]         grid_mem [DEPTH];
   logic [DEPTH-1:0]   cell_vld_ff;
   logic [2:0]         mem_q_ff;
   logic               vld_q_ff;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [2:0]         mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;
   logic               mem_re;
   logic               rd_in;
   logic [1:0]         rd_sel;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   phase_type          phase_ff, phase_in;
   logic [COORD_W-1:0] walker_row_ff, walker_row_in;
   logic [COORD_W-1:0] walker_col_ff, walker_col_in;
   logic [COORD_W-1:0] new_row_ff, new_row_in;
   logic [COORD_W-1:0] new_col_ff, new_col_in;
   status_type         status_ff, status_in;
   logic [1:0]         idx_ff, idx_in;
   logic               rd_pend_ff;
   logic [1:0]         rd_sel_ff;
   logic               rd_in_ff;
   logic [2:0]         nb_ff [4];
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_take;
   logic [2:0]         rd_value;
   logic [COORD_W:0]   nb_row [4];
   logic [COORD_W:0]   nb_col [4];
   logic               nb_in [4];
   logic               open_hit, once_hit;
   logic [1:0]         open_dir, once_dir;

   function automatic logic coord_ok(input logic [COORD_W:0] r, input logic [COORD_W:0] c);
      coord_ok = (r < (COORD_W+1)'(SPAN)) && (c < (COORD_W+1)'(SPAN));
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                   input logic [COORD_W-1:0] c);
      logic [2*COORD_W-1:0] lin;
      lin = {{COORD_W{1'b0}}, r} * (2*COORD_W)'(SPAN) + {{COORD_W{1'b0}}, c};
      cell_addr = lin[ADDR_W-1:0];
   endfunction

   assign req_stall = (state_ff != GMW_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // neighbours in order up, down, right, left
   always_comb begin
      nb_row[0] = {1'b0, walker_row_ff} - (COORD_W+1)'(1);
      nb_col[0] = {1'b0, walker_col_ff};
      nb_row[1] = {1'b0, walker_row_ff} + (COORD_W+1)'(1);
      nb_col[1] = {1'b0, walker_col_ff};
      nb_row[2] = {1'b0, walker_row_ff};
      nb_col[2] = {1'b0, walker_col_ff} + (COORD_W+1)'(1);
      nb_row[3] = {1'b0, walker_row_ff};
      nb_col[3] = {1'b0, walker_col_ff} - (COORD_W+1)'(1);
      for (int k = 0; k < 4; k++) begin
         nb_in[k] = coord_ok(nb_row[k], nb_col[k]);
      end
   end

   // open pass tries up, down, right, left; backtrack pass tries down, up, right, left
   always_comb begin
      open_hit = 1'b1;
      open_dir = 2'd0;
      if (nb_ff[0] == CELL_OPEN) begin
         open_dir = 2'd0;
      end else if (nb_ff[1] == CELL_OPEN) begin
         open_dir = 2'd1;
      end else if (nb_ff[2] == CELL_OPEN) begin
         open_dir = 2'd2;
      end else if (nb_ff[3] == CELL_OPEN) begin
         open_dir = 2'd3;
      end else begin
         open_hit = 1'b0;
      end
      once_hit = 1'b1;
      once_dir = 2'd1;
      if (nb_ff[1] == CELL_ONCE) begin
         once_dir = 2'd1;
      end else if (nb_ff[0] == CELL_ONCE) begin
         once_dir = 2'd0;
      end else if (nb_ff[2] == CELL_ONCE) begin
         once_dir = 2'd2;
      end else if (nb_ff[3] == CELL_ONCE) begin
         once_dir = 2'd3;
      end else begin
         once_hit = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      phase_in      = phase_ff;
      walker_row_in = walker_row_ff;
      walker_col_in = walker_col_ff;
      new_row_in    = new_row_ff;
      new_col_in    = new_col_ff;
      status_in     = status_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = CELL_WALL;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      rd_in         = 1'b0;
      rd_sel        = 2'd0;

      case (state_ff)
         GMW_IDLE: begin
            if (req_take) begin
               req_in = req_data;
               case (req_data.operation)
                  OP_LOAD: begin
                     mem_we    = coord_ok({1'b0, req_data.row}, {1'b0, req_data.col});
                     mem_waddr = cell_addr(req_data.row, req_data.col);
                     mem_wdata = (req_data.cell_kind == KIND_UNKNOWN) ? CELL_WALL
                                                              : {1'b0, req_data.cell_kind};
                     status_in = ST_LOADED;
                     state_in  = GMW_FINISH;
                  end
                  OP_START: begin
                     if (coord_ok({1'b0, req_data.row}, {1'b0, req_data.col})) begin
                        mem_re    = 1'b1;
                        mem_raddr = cell_addr(req_data.row, req_data.col);
                        rd_in     = 1'b1;
                        rd_sel    = 2'd0;
                        state_in  = GMW_LAST;
                     end else begin
                        status_in = ST_REJECT;
                        state_in  = GMW_FINISH;
                     end
                  end
                  OP_STEP: begin
                     if (phase_ff == PH_WALK) begin
                        idx_in   = 2'd0;
                        state_in = GMW_READ;
                     end else begin
                        status_in = (phase_ff == PH_ESC) ? ST_ESCAPED : ST_TRAPPED;
                        state_in  = GMW_FINISH;
                     end
                  end
                  default: begin
                     status_in = ST_TRAPPED;
                     state_in  = GMW_FINISH;
                  end
               endcase
            end
         end
         GMW_READ: begin
            mem_re    = 1'b1;
            rd_in     = nb_in[idx_ff];
            rd_sel    = idx_ff;
            mem_raddr = rd_in ? cell_addr(nb_row[idx_ff][COORD_W-1:0],
                                          nb_col[idx_ff][COORD_W-1:0]) : '0;
            idx_in    = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               state_in = GMW_LAST;
            end
         end
         GMW_LAST: begin
            state_in = GMW_DECIDE;
         end
         GMW_DECIDE: begin
            state_in = GMW_FINISH;
            if (req_ff.operation == OP_START) begin
               if (nb_ff[0] == CELL_WALL) begin
                  status_in = ST_REJECT;
               end else begin
                  mem_we        = 1'b1;
                  mem_waddr     = cell_addr(req_ff.row, req_ff.col);
                  mem_wdata     = CELL_HERE;
                  walker_row_in = req_ff.row;
                  walker_col_in = req_ff.col;
                  phase_in      = PH_WALK;
                  status_in     = ST_STARTED;
               end
            end else if (nb_ff[0] == CELL_EXIT || nb_ff[1] == CELL_EXIT ||
                         nb_ff[2] == CELL_EXIT || nb_ff[3] == CELL_EXIT) begin
               phase_in  = PH_ESC;
               status_in = ST_ESCAPED;
            end else if (open_hit || once_hit) begin
               // mark the cell left behind, move in next cycle
               mem_we     = 1'b1;
               mem_waddr  = cell_addr(walker_row_ff, walker_col_ff);
               mem_wdata  = open_hit ? CELL_ONCE : CELL_TWICE;
               new_row_in = open_hit ? nb_row[open_dir][COORD_W-1:0]
                                     : nb_row[once_dir][COORD_W-1:0];
               new_col_in = open_hit ? nb_col[open_dir][COORD_W-1:0]
                                     : nb_col[once_dir][COORD_W-1:0];
               state_in   = GMW_MOVE;
            end else begin
               phase_in  = PH_TRAP;
               status_in = ST_TRAPPED;
            end
         end
         GMW_MOVE: begin
            mem_we        = 1'b1;
            mem_waddr     = cell_addr(new_row_ff, new_col_ff);
            mem_wdata     = CELL_HERE;
            walker_row_in = new_row_ff;
            walker_col_in = new_col_ff;
            status_in     = ST_MOVED;
            state_in      = GMW_FINISH;
         end
         GMW_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.pos_row = walker_row_ff;
               rsp_data_in.pos_col = walker_col_ff;
               rsp_data_in.status  = status_ff;
               state_in            = GMW_IDLE;
            end
         end
         default: begin
            state_in = GMW_IDLE;
         end
      endcase
   end

   assign rd_value = (!rd_in_ff || !vld_q_ff) ? CELL_WALL : mem_q_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= grid_mem[mem_raddr];
         vld_q_ff <= cell_vld_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_vld_ff   <= '0;
         state_ff      <= GMW_IDLE;
         phase_ff      <= PH_IDLE;
         walker_row_ff <= '0;
         walker_col_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_pend_ff    <= 1'b0;
      end else begin
         if (mem_we) begin
            cell_vld_ff[mem_waddr] <= 1'b1;
         end
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         walker_row_ff <= walker_row_in;
         walker_col_ff <= walker_col_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_pend_ff    <= mem_re;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      new_row_ff  <= new_row_in;
      new_col_ff  <= new_col_in;
      status_ff   <= status_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      if (mem_re) begin
         rd_sel_ff <= rd_sel;
         rd_in_ff  <= rd_in;
      end
      if (rd_pend_ff) begin
         nb_ff[rd_sel_ff] <= rd_value;
      end
   end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the grid maze walker: directed, random-walk, stall and random-noise tests.
module tb_top;
   import gmw_pkg::*;

   localparam int          CYCLE_LIMIT  = 250000;
   localparam int          WALK_ITEMS   = 1450;
   localparam int          NOISE_ITEMS  = 200;
   localparam int          HOLD_CYCLES  = 120;
   localparam int          TAIL_CYCLES  = 20;
   localparam int          STEP_CAP     = 64;
   localparam logic [1:0]  OP_UNKNOWN   = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // walker predictor state
   cell_type  maze_grid [SPAN][SPAN];
   logic [3:0] walker_r;
   logic [3:0] walker_c;
   phase_type walk_state;

   rsp_type walker_reports [$];
   int      mismatch_count = 0;
   int      requests_sent  = 0;
   int      cycle_count    = 0;
   int      recv_wait      = 0;
   logic    hold_off       = 1'b0;
   bit      quiet          = 1'b0;

   grid_maze_walker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic int pick_gap();
      if (quiet)
         return 0;
      return $urandom_range(0, 3);
   endfunction

   // ---------------------------------------------------------------- predictor

   function automatic bit in_span(int r, int c);
      return r >= 0 && c >= 0 && r < SPAN && c < SPAN;
   endfunction

   function automatic cell_type maze_cell(int r, int c);
      if (!in_span(r, c))
         return CELL_WALL;
      return maze_grid[r][c];
   endfunction

   function automatic void set_cell(int r, int c, cell_type v);
      if (in_span(r, c))
         maze_grid[r][c] = v;
   endfunction

   function automatic bit walker_shift(bit backtrack);
      int       dr [4];
      int       dc [4];
      int       nr;
      int       nc;
      cell_type want;
      cell_type leave;
      if (backtrack) begin
         dr    = '{1, -1, 0, 0};
         want  = CELL_ONCE;
         leave = CELL_TWICE;
      end else begin
         dr    = '{-1, 1, 0, 0};
         want  = CELL_OPEN;
         leave = CELL_ONCE;
      end
      dc = '{0, 0, 1, -1};
      for (int k = 0; k < 4; k++) begin
         nr = int'(walker_r) + dr[k];
         nc = int'(walker_c) + dc[k];
         if (maze_cell(nr, nc) == want) begin
            set_cell(int'(walker_r), int'(walker_c), leave);
            set_cell(nr, nc, CELL_HERE);
            walker_r = nr[3:0];
            walker_c = nc[3:0];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic status_type walker_step();
      int r;
      int c;
      if (walk_state == PH_IDLE || walk_state == PH_TRAP)
         return ST_TRAPPED;
      if (walk_state == PH_ESC)
         return ST_ESCAPED;
      r = int'(walker_r);
      c = int'(walker_c);
      if (maze_cell(r + 1, c) == CELL_EXIT || maze_cell(r - 1, c) == CELL_EXIT ||
          maze_cell(r, c + 1) == CELL_EXIT || maze_cell(r, c - 1) == CELL_EXIT) begin
         walk_state = PH_ESC;
         return ST_ESCAPED;
      end
      if (walker_shift(1'b0))
         return ST_MOVED;
      if (walker_shift(1'b1))
         return ST_MOVED;
      walk_state = PH_TRAP;
      return ST_TRAPPED;
   endfunction

   function automatic rsp_type predict_walker(req_type q);
      rsp_type    res;
      status_type st;
      int         r;
      int         c;
      r = int'(q.row);
      c = int'(q.col);
      case (q.operation)
         OP_LOAD: begin
            set_cell(r, c, (q.cell_kind == KIND_UNKNOWN) ? CELL_WALL
                                                          : cell_type'({1'b0, q.cell_kind}));
            st = ST_LOADED;
         end
         OP_START: begin
            if (!in_span(r, c) || maze_cell(r, c) == CELL_WALL) begin
               st = ST_REJECT;
            end else begin
               set_cell(r, c, CELL_HERE);
               walker_r   = q.row;
               walker_c   = q.col;
               walk_state = PH_WALK;
               st         = ST_STARTED;
            end
         end
         OP_STEP: st = walker_step();
         default: st = ST_TRAPPED;
      endcase
      res.pos_row = walker_r;
      res.pos_col = walker_c;
      res.status  = st;
      return res;
   endfunction

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         recv_wait = pick_gap();
      else if (rsp_valid && recv_wait > 0)
         recv_wait--;
      rsp_stall <= !reset && (hold_off || recv_wait > 0);
   end

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (walker_reports.size() == 0) begin
            report_mismatch($sformatf("response with none pending: row %0d col %0d status %0d",
                                      rsp_data.pos_row, rsp_data.pos_col, rsp_data.status));
         end else begin
            want = walker_reports.pop_front();
            if (rsp_data.pos_row !== want.pos_row)
               report_mismatch($sformatf("pos_row %0d, predicted %0d",
                                         rsp_data.pos_row, want.pos_row));
            if (rsp_data.pos_col !== want.pos_col)
               report_mismatch($sformatf("pos_col %0d, predicted %0d",
                                         rsp_data.pos_col, want.pos_col));
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d, predicted %0d",
                                         rsp_data.status, want.status));
         end
      end
   end

   // ---------------------------------------------------------------- request side

   task automatic send_request(req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      walker_reports.push_back(predict_walker(item));
      requests_sent++;
   endtask

   task automatic issue(logic [1:0] op, int r, int c, logic [1:0] kind);
      req_type item;
      item.operation = op;
      item.row       = r[3:0];
      item.col       = c[3:0];
      item.cell_kind = kind;
      send_request(item);
   endtask

   task automatic load_cell(int r, int c, logic [1:0] kind);
      issue(OP_LOAD, r, c, kind);
   endtask

   task automatic place_walker(int r, int c);
      issue(OP_START, r, c, 2'($urandom_range(0, 3)));
   endtask

   task automatic take_step();
      issue(OP_STEP, $urandom_range(0, 15), $urandom_range(0, 15),
            2'($urandom_range(0, 3)));
   endtask

   task automatic send_noise();
      issue(2'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 15),
            2'($urandom_range(0, 3)));
   endtask

   // hold the request side low until every response is back
   task automatic wait_for_reports();
      req_valid <= 1'b0;
      do @(posedge clock); while (walker_reports.size() != 0);
   endtask

   function automatic logic [1:0] draw_kind();
      int x;
      x = $urandom_range(0, 99);
      if (x < 62)
         return KIND_OPEN;
      if (x < 86)
         return KIND_WALL;
      if (x < 92)
         return KIND_UNKNOWN;
      return KIND_EXIT;
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      issue(OP_STEP, 15, 15, KIND_UNKNOWN);      // step before any start
      issue(OP_UNKNOWN, 15, 0, KIND_EXIT);
      place_walker(0, 0);                        // wall after reset: rejected
      load_cell(0, 0, KIND_OPEN);
      load_cell(0, 1, KIND_OPEN);
      load_cell(1, 0, KIND_UNKNOWN);
      load_cell(15, 15, KIND_EXIT);
      load_cell(15, 14, KIND_OPEN);
      place_walker(0, 0);
      take_step();                               // top edge counts as wall, go right
      take_step();                               // dead end, back off left
      take_step();                               // trapped
      take_step();                               // trapped is kept
      load_cell(0, 0, KIND_OPEN);                // overwrite the walker's own cell
      place_walker(0, 1);                        // visited twice: still accepted
      place_walker(0, 1);                        // occupied: accepted
      place_walker(15, 14);
      take_step();                               // exit to the right
      take_step();                               // escape is kept
      issue(OP_UNKNOWN, 0, 15, KIND_WALL);
      place_walker(15, 15);                      // start on the exit itself
      take_step();
      load_cell(15, 0, KIND_WALL);
      place_walker(15, 0);
   endtask

   task automatic test_random_walks();
      int size;
      int r0;
      int c0;
      int walks;
      walks = 0;
      while (requests_sent < WALK_ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         size  = $urandom_range(2, 6);
         r0    = $urandom_range(0, 16 - size);
         c0    = $urandom_range(0, 16 - size);
         for (int r = r0; r < r0 + size; r++)
            for (int c = c0; c < c0 + size; c++)
               load_cell(r, c, draw_kind());
         if ($urandom_range(0, 9) == 0)
            send_noise();
         place_walker($urandom_range(r0, r0 + size - 1), $urandom_range(c0, c0 + size - 1));
         for (int n = 0; n < STEP_CAP && walk_state == PH_WALK; n++) begin
            take_step();
            // disturb the maze now and then mid-walk
            if ($urandom_range(0, 14) == 0)
               load_cell($urandom_range(r0, r0 + size - 1),
                         $urandom_range(c0, c0 + size - 1), draw_kind());
         end
         repeat ($urandom_range(0, 2)) take_step();
         walks++;
         if (walks % 8 == 0)
            wait_for_reports();
      end
      quiet = 1'b0;
   endtask

   task automatic test_output_hold_off();
      fork
         begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off <= 1'b0;
         end
      join_none
      quiet = 1'b1;
      repeat (30) begin
         if ($urandom_range(0, 1) == 0)
            take_step();
         else
            send_noise();
      end
      quiet = 1'b0;
      wait_for_reports();
   endtask

   task automatic test_random_noise();
      repeat (NOISE_ITEMS) send_noise();
   endtask

   initial begin
      for (int r = 0; r < SPAN; r++)
         for (int c = 0; c < SPAN; c++)
            maze_grid[r][c] = CELL_WALL;
      walker_r   = '0;
      walker_c   = '0;
      walk_state = PH_IDLE;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_walks();
      test_output_hold_off();
      test_random_noise();

      wait_for_reports();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/gmw_pkg.sv
rtl/grid_maze_walker.sv
bench/tb_top.sv
